FILE: sv/wsa_pkg.sv
// Package for the weighted similarity accumulate unit.
// Holds the shared constants, the logarithm step table and the control structs.
// Depends on nothing.
package wsa_pkg;

   localparam int MAX_DIM  = 1024;
   localparam int MAX_TAPS = 16;
   localparam int SUM_W    = 48;
   localparam int LN_STEPS = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_ROWS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_COLS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_ROWS     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_COLS     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_FUDGE        = 3'd7;

   localparam logic [25:0]        TWO_Q24     = 26'h2000000;
   localparam logic signed [31:0] LN2_Q24     = 32'sd11629080;
   localparam logic signed [24:0] HALF_LN_2PI = 25'sd60223;

   function automatic logic [23:0] ln_step_value(input logic [3:0] k);
      logic [23:0] v;
      case (k)
         4'd0:  v = 24'd6802576;
         4'd1:  v = 24'd3743728;
         4'd2:  v = 24'd1976071;
         4'd3:  v = 24'd1017112;
         4'd4:  v = 24'd516263;
         4'd5:  v = 24'd260117;
         4'd6:  v = 24'd130563;
         4'd7:  v = 24'd65408;
         4'd8:  v = 24'd32736;
         4'd9:  v = 24'd16376;
         4'd10: v = 24'd8190;
         4'd11: v = 24'd4096;
         4'd12: v = 24'd2048;
         4'd13: v = 24'd1024;
         4'd14: v = 24'd512;
         default: v = 24'd256;
      endcase
      return v;
   endfunction

   typedef struct packed {
      logic load;
      logic geom;
      logic square;
      logic multiply;
      logic norm_step;
      logic ln_step;
      logic finish;
      logic accum;
   } wsa_cmd_type;

   typedef struct packed {
      logic norm_en;
      logic y_top;
      logic ln_last;
      logic out_busy;
   } wsa_status_type;

endpackage

FILE: sv/wsa_ifs.sv
// Channel interfaces of the weighted similarity accumulate unit.
// One interface carries tap words, the other result words; no dependencies.
interface wsa_req_if;
   logic               valid;
   logic               ready;
   logic [9:0]         out_row;
   logic [9:0]         out_col;
   logic [3:0]         tap_row;
   logic [3:0]         tap_col;
   logic signed [15:0] pixel;
   logic               pixel_missing;
   logic signed [15:0] template_value;
   logic [23:0]        weight;
   logic               last_tap;
   modport source (output valid, out_row, out_col, tap_row, tap_col, pixel, pixel_missing,
                   template_value, weight, last_tap, input ready);
   modport sink (input valid, out_row, out_col, tap_row, tap_col, pixel, pixel_missing,
                 template_value, weight, last_tap, output ready);
endinterface

interface wsa_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] similarity_sum;
   logic               overflowed;
   modport source (output valid, similarity_sum, overflowed, input ready);
   modport sink (input valid, similarity_sum, overflowed, output ready);
endinterface

FILE: sv/wsa_ctrl.sv
// Controller state machine of the weighted similarity accumulate unit.
// Sequences the datapath through commands; uses wsa_pkg.
module wsa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  wsa_pkg::wsa_status_type status,
   output wsa_pkg::wsa_cmd_type    cmd
);
   import wsa_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_GEOM, S_SQUARE, S_MULT, S_NORM, S_LN, S_FINISH, S_ACCUM
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_valid && ready_ff) state_in = S_GEOM;
         S_GEOM:   state_in = S_SQUARE;
         S_SQUARE: state_in = S_MULT;
         S_MULT:   state_in = status.norm_en ? S_NORM : S_ACCUM;
         S_NORM:   if (status.y_top) state_in = S_LN;
         S_LN:     if (status.ln_last) state_in = S_FINISH;
         S_FINISH: state_in = S_ACCUM;
         S_ACCUM:  if (!status.out_busy) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
      ready_in = (state_in == S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.load      = (state_ff == S_IDLE) && req_valid && ready_ff;
      cmd.geom      = (state_ff == S_GEOM);
      cmd.square    = (state_ff == S_SQUARE);
      cmd.multiply  = (state_ff == S_MULT);
      cmd.norm_step = (state_ff == S_NORM);
      cmd.ln_step   = (state_ff == S_LN);
      cmd.finish    = (state_ff == S_FINISH);
      cmd.accum     = (state_ff == S_ACCUM) && !status.out_busy;
   end

   assign req_ready = ready_ff;

endmodule

FILE: sv/wsa_dp.sv
// Datapath of the weighted similarity accumulate unit: configuration registers,
// tap geometry, distance products, the logarithm iteration and the saturating sum.
// Uses wsa_pkg and is driven by commands from wsa_ctrl.
module wsa_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [wsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wsa_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  wsa_pkg::wsa_cmd_type           cmd,
   output wsa_pkg::wsa_status_type        status,
   input  logic [9:0]                     in_out_row,
   input  logic [9:0]                     in_out_col,
   input  logic [3:0]                     in_tap_row,
   input  logic [3:0]                     in_tap_col,
   input  logic signed [15:0]             in_pixel,
   input  logic                           in_pixel_missing,
   input  logic signed [15:0]             in_template_value,
   input  logic [23:0]                    in_weight,
   input  logic                           in_last_tap,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic signed [47:0]             out_similarity_sum,
   output logic                           out_overflowed
);
   import wsa_pkg::*;

   localparam int ACC_W = ((SUM_W > 58) ? SUM_W : 58) + 2;
   localparam logic signed [SUM_W-1:0] SUM_HI = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_LO = {1'b1, {(SUM_W-1){1'b0}}};

   logic [2:0]  mode_ff;
   logic [4:0]  stride_rows_ff, stride_cols_ff;
   logic [3:0]  pad_rows_ff, pad_cols_ff;
   logic [10:0] image_height_ff, image_width_ff;
   logic [15:0] fudge_ff;

   logic [9:0]         orow_ff, ocol_ff;
   logic [3:0]         trow_ff, tcol_ff;
   logic signed [15:0] pix_ff, tmpl_ff;
   logic               miss_ff, last_ff;
   logic [23:0]        w_ff;

   logic               skip_ff;
   logic [16:0]        ad_ff;
   logic [32:0]        adsq_ff;
   logic [56:0]        prod_ff;
   logic [25:0]        y_ff;
   logic [4:0]         b_ff;
   logic [3:0]         k_ff;
   logic [24:0]        lnacc_ff;
   logic signed [24:0] hl_ff;

   logic signed [SUM_W-1:0] sum_ff;
   logic                    sat_ff;
   logic                    rsp_valid_ff;
   logic signed [47:0]      rsp_sum_ff;
   logic                    rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= 3'd1;
         stride_rows_ff  <= 5'd2;
         stride_cols_ff  <= 5'd2;
         pad_rows_ff     <= 4'd0;
         pad_cols_ff     <= 4'd0;
         image_height_ff <= 11'd1024;
         image_width_ff  <= 11'd1024;
         fudge_ff        <= 16'd66;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MODE:         mode_ff         <= csr_write_data[2:0];
            CSR_STRIDE_ROWS:  stride_rows_ff  <= csr_write_data[4:0];
            CSR_STRIDE_COLS:  stride_cols_ff  <= csr_write_data[4:0];
            CSR_PAD_ROWS:     pad_rows_ff     <= csr_write_data[3:0];
            CSR_PAD_COLS:     pad_cols_ff     <= csr_write_data[3:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_write_data[10:0];
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_write_data[10:0];
            CSR_FUDGE:        fudge_ff        <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic [14:0]        rprod, cprod;
   logic signed [16:0] r, c;
   logic [10:0]        h_lim, w_lim;
   logic               in_image, tap_out;
   logic signed [16:0] pe, d;
   logic [24:0]        x;

   always_comb begin
      rprod   = orow_ff * stride_rows_ff;
      cprod   = ocol_ff * stride_cols_ff;
      r       = $signed({2'b0, rprod}) - $signed({13'b0, pad_rows_ff})
                + $signed({13'b0, trow_ff});
      c       = $signed({2'b0, cprod}) - $signed({13'b0, pad_cols_ff})
                + $signed({13'b0, tcol_ff});
      h_lim   = (image_height_ff > 11'(MAX_DIM)) ? 11'(MAX_DIM) : image_height_ff;
      w_lim   = (image_width_ff > 11'(MAX_DIM)) ? 11'(MAX_DIM) : image_width_ff;
      in_image = !r[16] && (r[15:0] < {5'b0, h_lim}) && !c[16]
                 && (c[15:0] < {5'b0, w_lim});
      tap_out = (int'(trow_ff) >= MAX_TAPS) || (int'(tcol_ff) >= MAX_TAPS);
      pe      = in_image ? 17'(pix_ff) : 17'sd0;
      d       = pe - 17'(tmpl_ff);
      x       = {1'b0, w_ff} + {9'b0, fudge_ff};
      if (x == 25'd0) x = 25'd1;
   end

   logic [25:0] ln_t;
   logic [4:0]  ln_sh;

   always_comb begin
      ln_sh = {1'b0, k_ff} + 5'd1;
      ln_t  = y_ff + (y_ff >> ln_sh);
   end

   logic signed [31:0] lnm, lnx, bm32;
   logic [31:0]        lmag;
   logic [22:0]        lrnd;
   logic signed [24:0] half_ln;

   always_comb begin
      lnm     = LN2_Q24 - $signed({7'b0, lnacc_ff}) - $signed({6'b0, (TWO_Q24 - y_ff) >> 1});
      bm32    = $signed({27'b0, b_ff}) - 32'sd16;
      lnx     = bm32 * LN2_Q24 + lnm;
      lmag    = lnx[31] ? 32'(-lnx) : 32'(lnx);
      lrnd    = 23'((lmag + 32'd256) >> 9);
      half_ln = lnx[31] ? -$signed({2'b0, lrnd}) : $signed({2'b0, lrnd});
   end

   logic [57:0]             pr, mg;
   logic signed [ACC_W-1:0] v, tot, sum_ext;
   logic signed [SUM_W-1:0] nsum;
   logic                    nsat;
   logic signed [63:0]      sum64;

   always_comb begin
      pr = {1'b0, prod_ff};
      case ({mode_ff[0], mode_ff[1]})
         2'b00:   mg = (pr + 58'd128) >> 8;
         2'b01:   mg = (pr + 58'd256) >> 9;
         2'b10:   mg = (pr + 58'd32768) >> 16;
         default: mg = (pr + 58'd65536) >> 17;
      endcase
      v       = -$signed(ACC_W'(mg)) + (mode_ff[1] ? ACC_W'(hl_ff) : ACC_W'(0));
      sum_ext = ACC_W'(sum_ff);
      tot     = sum_ext + v;
      nsum    = sum_ff;
      nsat    = sat_ff;
      if (!skip_ff) begin
         if (tot > ACC_W'(SUM_HI)) begin
            nsum = SUM_HI;
            nsat = 1'b1;
         end else if (tot < ACC_W'(SUM_LO)) begin
            nsum = SUM_LO;
            nsat = 1'b1;
         end else begin
            nsum = tot[SUM_W-1:0];
         end
      end
      sum64 = 64'(nsum);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         orow_ff <= in_out_row;
         ocol_ff <= in_out_col;
         trow_ff <= in_tap_row;
         tcol_ff <= in_tap_col;
         pix_ff  <= in_pixel;
         miss_ff <= in_pixel_missing;
         tmpl_ff <= in_template_value;
         w_ff    <= in_weight;
         last_ff <= in_last_tap;
      end
      if (cmd.geom) begin
         skip_ff  <= tap_out || (in_image && miss_ff && mode_ff[2]);
         ad_ff    <= d[16] ? 17'(-d) : 17'(d);
         y_ff     <= {1'b0, x};
         b_ff     <= 5'd24;
         k_ff     <= 4'd0;
         lnacc_ff <= 25'd0;
      end
      if (cmd.square) adsq_ff <= 33'(ad_ff * ad_ff);
      if (cmd.multiply) prod_ff <= w_ff * (mode_ff[0] ? adsq_ff : {16'b0, ad_ff});
      if (cmd.norm_step && !y_ff[24]) begin
         y_ff <= y_ff << 1;
         b_ff <= b_ff - 5'd1;
      end
      if (cmd.ln_step) begin
         if (ln_t <= TWO_Q24) begin
            y_ff     <= ln_t;
            lnacc_ff <= lnacc_ff + {1'b0, ln_step_value(k_ff)};
         end
         k_ff <= k_ff + 4'd1;
      end
      if (cmd.finish) hl_ff <= half_ln - HALF_LN_2PI;
      if (cmd.accum && last_ff) begin
         rsp_sum_ff <= sum64[47:0];
         rsp_ovf_ff <= nsat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accum) begin
            sum_ff <= last_ff ? '0 : nsum;
            sat_ff <= last_ff ? 1'b0 : nsat;
         end
         if (cmd.accum && last_ff) rsp_valid_ff <= 1'b1;
         else if (out_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      status          = '0;
      status.norm_en  = mode_ff[1];
      status.y_top    = y_ff[24];
      status.ln_last  = (k_ff == 4'(LN_STEPS - 1));
      status.out_busy = rsp_valid_ff && !out_ready;
   end

   assign out_valid          = rsp_valid_ff;
   assign out_similarity_sum = rsp_sum_ff;
   assign out_overflowed     = rsp_ovf_ff;

endmodule

FILE: sv/weighted_similarity_accumulate_unit.sv
// Top level of the weighted similarity accumulate unit.
// Joins wsa_ctrl and wsa_dp; uses wsa_pkg and the channel interfaces of wsa_ifs.
//
// The req_chan channel takes one window tap per word: output position, tap offset,
// pixel, missing mark, template value, weight and the last-tap mark. The rsp_chan
// channel returns one word per output element, sent when its last tap has been
// added: the saturated signed Q32.16 sum and an overflow flag.
// The csr_ port writes the eight configuration registers, one per cycle; the user
// must write them only while the unit is idle, which the block does not enforce.
// In L1 or L2 mode a tap passes the geometry, square, multiply and accumulate steps
// from acceptance back to idle. With the normalization term it also passes the
// one-bit-per-cycle normalizing shift, the logarithm iteration and a step that forms
// the term before the accumulate step. One tap is in work at a time.
// A result waits in an output register; the next tap is taken meanwhile, and the
// unit holds in its final step while the previous result is still not taken.
// Reset is synchronous: registers return to their defaults and the sum and the
// overflow flag are cleared.
module weighted_similarity_accumulate_unit (
   input  logic                           clock,
   input  logic                           reset,
   wsa_req_if.sink                        req_chan,
   wsa_rsp_if.source                      rsp_chan,
   input  logic                           csr_write_enable,
   input  logic [wsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wsa_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import wsa_pkg::*;

   wsa_cmd_type    cmd;
   wsa_status_type status;

   wsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wsa_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .cmd                (cmd),
      .status             (status),
      .in_out_row         (req_chan.out_row),
      .in_out_col         (req_chan.out_col),
      .in_tap_row         (req_chan.tap_row),
      .in_tap_col         (req_chan.tap_col),
      .in_pixel           (req_chan.pixel),
      .in_pixel_missing   (req_chan.pixel_missing),
      .in_template_value  (req_chan.template_value),
      .in_weight          (req_chan.weight),
      .in_last_tap        (req_chan.last_tap),
      .out_valid          (rsp_chan.valid),
      .out_ready          (rsp_chan.ready),
      .out_similarity_sum (rsp_chan.similarity_sum),
      .out_overflowed     (rsp_chan.overflowed)
   );

endmodule
